>>> rtl/tgf_pkg.sv
package tgf_pkg;

  // Operation codes carried by the func field.
  localparam logic [1:0] FN_ASSIGN  = 2'd0;
  localparam logic [1:0] FN_ENQUEUE = 2'd1;
  localparam logic [1:0] FN_DEQUEUE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_DEQUEUED = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_DROPPED  = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [9:0] element;
    logic [3:0] team;
  } tgf_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] out_element;
    logic [3:0] out_team;
  } tgf_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clr;
    logic       load;
    logic       asg_wr;
    logic       enq_alloc;
    logic       enq_link;
    logic       deq_team;
    logic       deq_entry;
    logic       deq_finish;
    logic       res_load;
    logic [1:0] res_status;
  } tgf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic store_full;
    logic order_empty;
    logic out_free;
  } tgf_stat_t;

  // Remainder of a 10-bit value by a fixed modulus of at least 2, given
  // with its reciprocal scaled by 2**20 and rounded down. The quotient
  // estimate is low by at most one, so one compare and subtract finishes.
  function automatic logic [9:0] mod_reduce(input logic [9:0]  value,
                                            input logic [20:0] recip,
                                            input logic [20:0] modulus);
    logic [30:0] prod;
    logic [9:0]  quot;
    logic [30:0] rem;
    prod = 31'(value) * 31'(recip);
    quot = prod[29:20];
    rem  = 31'(value) - 31'(quot) * 31'(modulus);
    if (rem >= 31'(modulus)) begin
      rem = rem - 31'(modulus);
    end
    return rem[9:0];
  endfunction

endpackage

>>> rtl/tgf_ctrl.sv
module tgf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_func,
  output logic              in_ready,
  output tgf_pkg::tgf_cmd_t cmd,
  input  tgf_pkg::tgf_stat_t stat
);
  import tgf_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR      = 11'b000_0000_0001,
    S_IDLE       = 11'b000_0000_0010,
    S_ASSIGN     = 11'b000_0000_0100,
    S_NOOP       = 11'b000_0000_1000,
    S_ENQ_CHECK  = 11'b000_0001_0000,
    S_ENQ_ALLOC  = 11'b000_0010_0000,
    S_ENQ_LINK   = 11'b000_0100_0000,
    S_DEQ_CHECK  = 11'b000_1000_0000,
    S_DEQ_TEAM   = 11'b001_0000_0000,
    S_DEQ_ENTRY  = 11'b010_0000_0000,
    S_DEQ_FINISH = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_func)
            FN_ASSIGN:  state_next = S_ASSIGN;
            FN_ENQUEUE: state_next = S_ENQ_CHECK;
            FN_DEQUEUE: state_next = S_DEQ_CHECK;
            default:    state_next = S_NOOP;
          endcase
        end
      end
      S_ASSIGN: begin
        if (stat.out_free) begin
          cmd.asg_wr     = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_DONE;
          state_next     = S_IDLE;
        end
      end
      S_NOOP: begin
        if (stat.out_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_DONE;
          state_next     = S_IDLE;
        end
      end
      S_ENQ_CHECK: begin
        if (stat.store_full) begin
          if (stat.out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_DROPPED;
            state_next     = S_IDLE;
          end
        end else begin
          state_next = S_ENQ_ALLOC;
        end
      end
      S_ENQ_ALLOC: begin
        cmd.enq_alloc = 1'b1;
        state_next    = S_ENQ_LINK;
      end
      S_ENQ_LINK: begin
        if (stat.out_free) begin
          cmd.enq_link   = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_DONE;
          state_next     = S_IDLE;
        end
      end
      S_DEQ_CHECK: begin
        if (stat.order_empty) begin
          if (stat.out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_EMPTY;
            state_next     = S_IDLE;
          end
        end else begin
          state_next = S_DEQ_TEAM;
        end
      end
      S_DEQ_TEAM: begin
        cmd.deq_team = 1'b1;
        state_next   = S_DEQ_ENTRY;
      end
      S_DEQ_ENTRY: begin
        cmd.deq_entry = 1'b1;
        state_next    = S_DEQ_FINISH;
      end
      S_DEQ_FINISH: begin
        if (stat.out_free) begin
          cmd.deq_finish = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_DEQUEUED;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/tgf_datapath.sv
module tgf_datapath #(
  parameter int ELEMENTS = 1024,
  parameter int TEAMS    = 16,
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  tgf_pkg::tgf_cmd_t  cmd,
  output tgf_pkg::tgf_stat_t stat,
  input  tgf_pkg::tgf_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tgf_pkg::tgf_out_t  out_data
);
  import tgf_pkg::*;

  localparam int EAW      = $clog2(ELEMENTS);
  localparam int TAW      = $clog2(TEAMS);
  localparam int SAW      = $clog2(CAPACITY);
  localparam int CLR_N    = (ELEMENTS > TEAMS) ? ELEMENTS : TEAMS;
  localparam int CAW      = $clog2(CLR_N);
  localparam int EL_RECIP = (1 << 20) / ELEMENTS;
  localparam int TM_RECIP = (1 << 20) / TEAMS;

  // Item registers and working registers.
  logic [9:0]     el_r;
  logic [TAW-1:0] tm_r;
  logic [SAW-1:0] slot_r;
  logic           last_r;

  // Store bookkeeping: never-used entries come from fresh, returned ones sit
  // on the free stack of depth sp.
  logic [SAW:0]   sp;
  logic [SAW:0]   fresh;
  logic [TAW-1:0] order_head;
  logic [TAW-1:0] order_tail;
  logic [TAW:0]   order_count;
  logic [CAW-1:0] clr_addr;

  logic [TAW-1:0] team_mem  [ELEMENTS];
  logic           wait_mem  [TEAMS];
  logic [SAW-1:0] head_mem  [TEAMS];
  logic [SAW-1:0] tail_mem  [TEAMS];
  logic [TAW-1:0] order_mem [TEAMS];
  logic [9:0]     value_mem [CAPACITY];
  logic [SAW-1:0] next_mem  [CAPACITY];
  logic [SAW-1:0] stack_mem [CAPACITY];

  logic [TAW-1:0] team_rd;
  logic           wait_rd;
  logic [SAW-1:0] head_rd;
  logic [SAW-1:0] tail_rd;
  logic [TAW-1:0] order_rd;
  logic [9:0]     value_rd;
  logic [SAW-1:0] next_rd;
  logic [SAW-1:0] stack_rd;

  logic [EAW-1:0] el_idx;
  logic [TAW-1:0] team_sel;
  logic           clr_el_ok;
  logic           clr_tm_ok;
  logic           new_team;
  logic           team_leaves;

  function automatic logic [TAW-1:0] ring_next(input logic [TAW-1:0] p);
    return (p == TAW'(TEAMS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign el_idx      = EAW'(el_r);
  // Once the team of the item sits in tm_r, the per-team reads keep
  // following it, so a stall before the commit leaves them intact.
  assign team_sel    = cmd.enq_alloc ? team_rd : (cmd.deq_team ? order_rd : tm_r);
  assign clr_el_ok   = {1'b0, clr_addr} < (CAW + 1)'(ELEMENTS);
  assign clr_tm_ok   = {1'b0, clr_addr} < (CAW + 1)'(TEAMS);
  assign new_team    = cmd.enq_link && !wait_rd;
  assign team_leaves = cmd.deq_finish && last_r;

  assign stat.clr_done    = clr_addr == CAW'(CLR_N - 1);
  assign stat.store_full  = (fresh == (SAW + 1)'(CAPACITY)) && (sp == '0);
  assign stat.order_empty = order_count == '0;
  assign stat.out_free    = !out_valid || out_ready;

  // Control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp          <= '0;
      fresh       <= '0;
      order_head  <= '0;
      order_tail  <= '0;
      order_count <= '0;
      clr_addr    <= '0;
    end else begin
      if (cmd.clr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.enq_alloc) begin
        if (sp != '0) begin
          sp <= sp - 1'b1;
        end else begin
          fresh <= fresh + 1'b1;
        end
      end
      if (cmd.deq_finish) begin
        sp <= sp + 1'b1;
      end
      if (new_team) begin
        order_tail  <= ring_next(order_tail);
        order_count <= order_count + 1'b1;
      end
      if (team_leaves) begin
        order_head  <= ring_next(order_head);
        order_count <= order_count - 1'b1;
      end
    end
  end

  // Item and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      el_r <= mod_reduce(in_data.element, 21'(EL_RECIP), 21'(ELEMENTS));
      tm_r <= TAW'(mod_reduce(10'(in_data.team), 21'(TM_RECIP), 21'(TEAMS)));
    end
    if (cmd.enq_alloc || cmd.deq_team) begin
      tm_r <= team_sel;
    end
    if (cmd.enq_alloc) begin
      slot_r <= (sp != '0) ? stack_rd : SAW'(fresh);
    end
    if (cmd.deq_entry) begin
      slot_r <= head_rd;
      last_r <= head_rd == tail_rd;
    end
  end

  // Team table, cleared by the sweep after reset.
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      if (clr_el_ok) begin
        team_mem[EAW'(clr_addr)] <= '0;
      end
    end else if (cmd.asg_wr) begin
      team_mem[el_idx] <= tm_r;
    end
    team_rd <= team_mem[el_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      if (clr_tm_ok) begin
        wait_mem[TAW'(clr_addr)] <= 1'b0;
      end
    end else if (new_team) begin
      wait_mem[tm_r] <= 1'b1;
    end else if (team_leaves) begin
      wait_mem[tm_r] <= 1'b0;
    end
    wait_rd <= wait_mem[team_sel];
  end

  always_ff @(posedge clk) begin
    if (new_team) begin
      head_mem[tm_r] <= slot_r;
    end else if (cmd.deq_finish && !last_r) begin
      head_mem[tm_r] <= next_rd;
    end
    head_rd <= head_mem[team_sel];
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_link) begin
      tail_mem[tm_r] <= slot_r;
    end
    tail_rd <= tail_mem[team_sel];
  end

  always_ff @(posedge clk) begin
    if (new_team) begin
      order_mem[order_tail] <= tm_r;
    end
    order_rd <= order_mem[order_head];
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_link) begin
      value_mem[slot_r] <= el_r;
    end
    value_rd <= value_mem[head_rd];
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_link && wait_rd) begin
      next_mem[tail_rd] <= slot_r;
    end
    next_rd <= next_mem[head_rd];
  end

  always_ff @(posedge clk) begin
    if (cmd.deq_finish) begin
      stack_mem[SAW'(sp)] <= slot_r;
    end
    stack_rd <= stack_mem[SAW'(sp - 1'b1)];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data.status <= cmd.res_status;
      if (cmd.res_status == ST_DEQUEUED) begin
        out_data.out_element <= value_rd;
        out_data.out_team    <= 4'(tm_r);
      end else begin
        out_data.out_element <= '0;
        out_data.out_team    <= '0;
      end
    end
  end

  a_stack_within_used: assert property (@(posedge clk) disable iff (rst)
    sp <= fresh) else $error("free stack deeper than entries handed out");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh <= (SAW + 1)'(CAPACITY)) else $error("fresh count beyond capacity");

  a_order_bound: assert property (@(posedge clk) disable iff (rst)
    order_count <= (TAW + 1)'(TEAMS)) else $error("order queue overfilled");

  a_order_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (order_count == '0) |-> (order_head == order_tail))
    else $error("empty order queue with unequal pointers");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("result loaded over an item not yet taken");

endmodule

>>> rtl/team_grouped_fifo.sv
// Team queue. An assign item records the team of an element id (ids never
// assigned belong to team 0), an enqueue item appends the element to its
// team's FIFO and puts the team at the back of the team order when it had
// nothing waiting, and a dequeue item returns the oldest element of the team
// at the front of that order, together with its team; a team whose FIFO
// runs dry leaves the order. Every item gives exactly one result item: done,
// dequeued, empty on a dequeue with nothing waiting, or dropped on an enqueue
// when all CAPACITY entries of the shared element store are in use. Element
// ids and team numbers beyond ELEMENTS and TEAMS wrap modulo those sizes.
// After reset the block clears the team table and the per-team waiting
// flags over max(ELEMENTS, TEAMS) addresses, with in_ready low. After that
// an enqueue and a dequeue step through a chain of registered memory reads
// through the team table, the per-team head and tail tables and the element
// store; an assign, an unused code, a dropped enqueue and an empty dequeue
// give their result without it. One item is worked at a time, and the next
// one is taken while the previous result still waits in the output register.
module team_grouped_fifo #(
  parameter int ELEMENTS = 1024,
  parameter int TEAMS    = 16,
  parameter int CAPACITY = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tgf_pkg::tgf_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tgf_pkg::tgf_out_t out_data
);
  import tgf_pkg::*;

  // Command and status between the sequencer and the datapath.
  tgf_cmd_t  cmd;
  tgf_stat_t stat;

  // The controller steps each item through its memory reads and commits
  // the updates only in the cycle the output register can take the result.
  tgf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // The datapath holds the team table, the linked element store with its
  // free stack, the per-team head and tail pointers and the team order ring.
  tgf_datapath #(
    .ELEMENTS (ELEMENTS),
    .TEAMS    (TEAMS),
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tgf_pkg::*;

  // The func field has one code the package leaves unnamed; the block must
  // treat it as a no-op that still answers with a done result.
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam int ELEMENTS    = 1024;
  localparam int TEAMS       = 16;
  localparam int CAPACITY    = 256;
  localparam int LONG_STALL  = 400;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PRINT_CAP   = 50;
  localparam int N_DIRECTED  = 22;

  // Flavors of random traffic. Filling pushes the shared store until it
  // overflows, draining empties the team order, mixed keeps it hovering.
  typedef enum logic [1:0] {SEG_MIXED, SEG_FILL, SEG_DRAIN} seg_t;

  // One row of the directed table. When typed is set, want is the result
  // written by hand; otherwise the predictor supplies it.
  typedef struct packed {
    tgf_in_t  item;
    logic     typed;
    tgf_out_t want;
  } stim_row_t;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  tgf_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  tgf_out_t out_data;

  team_grouped_fifo #(
    .ELEMENTS (ELEMENTS),
    .TEAMS    (TEAMS),
    .CAPACITY (CAPACITY)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Shadow copy of the team queue. The linked store mirrors the block's:
  // free entries are handed out from a stack, each team keeps a head and
  // tail pointer into the store, and waiting teams sit in a small ring.
  logic [3:0] team_tab   [ELEMENTS];
  logic [9:0] entry_elem [CAPACITY];
  logic [7:0] entry_link [CAPACITY];
  logic [7:0] free_stack [CAPACITY];
  logic [8:0] free_cnt;
  logic [7:0] team_first [TEAMS];
  logic [7:0] team_last  [TEAMS];
  logic       team_busy  [TEAMS];
  logic [3:0] team_order [TEAMS];
  logic [3:0] order_rd;
  logic [3:0] order_wr;
  logic [4:0] order_len;

  tgf_out_t   expected_results [$];
  stim_row_t  directed_rows    [N_DIRECTED];
  tgf_out_t   got_want;
  int         errors;
  int         cycle_count;
  int         hold_left;
  bit         long_stall_req;
  bit         quiet;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one item to the shadow queue and return the result it causes.
  // Element ids and team numbers are already at the block's widths, so the
  // modulo wrap of the default sizes is implicit in the indexing.
  function tgf_out_t queue_step(input tgf_in_t it);
    tgf_out_t   res;
    logic [3:0] tm;
    logic [7:0] slot;
    res = '0;
    case (it.func)
      FN_ASSIGN: begin
        team_tab[it.element] = it.team;
      end
      FN_ENQUEUE: begin
        tm = team_tab[it.element];
        if (free_cnt == 9'd0) begin
          res.status = ST_DROPPED;
        end else begin
          free_cnt         = free_cnt - 9'd1;
          slot             = free_stack[free_cnt[7:0]];
          entry_elem[slot] = it.element;
          entry_link[slot] = 8'd0;
          if (team_busy[tm]) begin
            entry_link[team_last[tm]] = slot;
            team_last[tm]             = slot;
          end else begin
            // The team had nothing waiting, so it joins the back of the order.
            team_first[tm]       = slot;
            team_last[tm]        = slot;
            team_busy[tm]        = 1'b1;
            team_order[order_wr] = tm;
            order_wr             = order_wr + 4'd1;
            order_len            = order_len + 5'd1;
          end
          res.status = ST_DONE;
        end
      end
      FN_DEQUEUE: begin
        if (order_len == 5'd0) begin
          res.status = ST_EMPTY;
        end else begin
          tm              = team_order[order_rd];
          slot            = team_first[tm];
          res.status      = ST_DEQUEUED;
          res.out_element = entry_elem[slot];
          res.out_team    = tm;
          if (slot == team_last[tm]) begin
            // Last element of this team: the team leaves the order.
            team_busy[tm] = 1'b0;
            order_rd      = order_rd + 4'd1;
            order_len     = order_len - 5'd1;
          end else begin
            team_first[tm] = entry_link[slot];
          end
          free_stack[free_cnt[7:0]] = slot;
          free_cnt                  = free_cnt + 9'd1;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Every mismatch goes through here: one line, one count. Printing stops
  // after a while so that a broken block cannot flood the log.
  task note_error(input string msg);
    if (errors < PRINT_CAP) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  // Offer one item and hold it until the block takes it. Valid is raised at
  // a falling edge and left high; the next call or an idle stretch decides
  // whether it comes down, so it is never lowered and raised in one step.
  task offer(input tgf_in_t it, input logic typed, input tgf_out_t want);
    tgf_out_t predicted;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predicted = queue_step(it);
    expected_results.insert(expected_results.size(), typed ? want : predicted);
  endtask

  task idle_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task wait_drained();
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function tgf_in_t random_item(input seg_t mode);
    tgf_in_t     it;
    int unsigned pick;
    int unsigned lim_asg;
    int unsigned lim_enq;
    int unsigned lim_deq;
    case (mode)
      SEG_FILL: begin
        lim_asg = 10; lim_enq = 90; lim_deq = 98;
      end
      SEG_DRAIN: begin
        lim_asg = 10; lim_enq = 25; lim_deq = 98;
      end
      default: begin
        lim_asg = 25; lim_enq = 60; lim_deq = 97;
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < lim_asg) begin
      it.func = FN_ASSIGN;
    end else if (pick < lim_enq) begin
      it.func = FN_ENQUEUE;
    end else if (pick < lim_deq) begin
      it.func = FN_DEQUEUE;
    end else begin
      it.func = FN_UNUSED;
    end
    // Most ids come from a small pool so that assigned teams actually get
    // used by later enqueues; the rest sweep the whole id range.
    if ($urandom_range(0, 3) == 0) begin
      it.element = 10'($urandom_range(0, ELEMENTS - 1));
    end else begin
      it.element = 10'($urandom_range(0, 47));
    end
    it.team = 4'($urandom_range(0, TEAMS - 1));
    return it;
  endfunction

  // A run of random items. With idling on, the sender pauses in random
  // bursts; the first few items can be exempted so that they keep pressing
  // on the input while the receiver is held off.
  task run_segment(input seg_t mode, input int count, input bit idle_on,
                   input int eager_items);
    tgf_in_t it;
    for (int n = 0; n < count; n++) begin
      if (idle_on && n >= eager_items && $urandom_range(0, 9) == 0) begin
        idle_sender($urandom_range(1, 17));
      end
      it = random_item(mode);
      offer(it, 1'b0, '0);
    end
  endtask

  // Result side: each handshake is checked field by field against the
  // oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_error($sformatf("result with nothing expected: status %0d el %0d team %0d",
                             out_data.status, out_data.out_element, out_data.out_team));
      end else begin
        got_want = expected_results.pop_front();
        if (out_data.status !== got_want.status) begin
          note_error($sformatf("status got %0d want %0d",
                               out_data.status, got_want.status));
        end
        if (out_data.out_element !== got_want.out_element) begin
          note_error($sformatf("out_element got %0d want %0d",
                               out_data.out_element, got_want.out_element));
        end
        if (out_data.out_team !== got_want.out_team) begin
          note_error($sformatf("out_team got %0d want %0d",
                               out_data.out_team, got_want.out_team));
        end
      end
    end
  end

  // Watchdog. The limit covers the clearing pass after reset, the long
  // receiver hold-off and worst-case gaps on both sides many times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Receiver. It drops ready in random bursts, honors one long hold-off on
  // request, and stays ready throughout the quiet tail of the run.
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (long_stall_req) begin
        long_stall_req = 1'b0;
        hold_left      = LONG_STALL - 1;
        out_ready      <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Shadow state after reset: empty team table, full free stack.
  initial begin
    for (int i = 0; i < ELEMENTS; i++) begin
      team_tab[i] = 4'd0;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      free_stack[i] = 8'(i);
      entry_elem[i] = 10'd0;
      entry_link[i] = 8'd0;
    end
    for (int i = 0; i < TEAMS; i++) begin
      team_busy[i]  = 1'b0;
      team_first[i] = 8'd0;
      team_last[i]  = 8'd0;
      team_order[i] = 4'd0;
    end
    free_cnt  = 9'(CAPACITY);
    order_rd  = 4'd0;
    order_wr  = 4'd0;
    order_len = 5'd0;
  end

  // Stimulus.
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    errors         = 0;
    cycle_count    = 0;
    long_stall_req = 1'b0;
    quiet          = 1'b0;

    // Directed table. A dequeue straight after reset must report empty, the
    // unused code must be a no-op, and ids at both ends of the range as well
    // as alternating bit patterns are assigned and queued. Team 15 goes
    // first, then team 0 (ids that were never assigned), then teams 10 and
    // 5, so the dequeues walk the order in arrival order of the teams and
    // FIFO order within team 0. A final pair reuses one id twice in a team.
    directed_rows = '{
      '{'{FN_DEQUEUE, 10'd0,    4'd0},  1'b1, '{ST_EMPTY, 10'd0, 4'd0}},
      '{'{FN_UNUSED,  10'd1023, 4'd15}, 1'b1, '{ST_DONE,  10'd0, 4'd0}},
      '{'{FN_ASSIGN,  10'd1023, 4'd15}, 1'b1, '{ST_DONE,  10'd0, 4'd0}},
      '{'{FN_ASSIGN,  10'd682,  4'd10}, 1'b1, '{ST_DONE,  10'd0, 4'd0}},
      '{'{FN_ASSIGN,  10'd341,  4'd5},  1'b1, '{ST_DONE,  10'd0, 4'd0}},
      '{'{FN_ENQUEUE, 10'd1023, 4'd3},  1'b1, '{ST_DONE,  10'd0, 4'd0}},
      '{'{FN_ENQUEUE, 10'd0,    4'd15}, 1'b1, '{ST_DONE,  10'd0, 4'd0}},
      '{'{FN_ENQUEUE, 10'd682,  4'd0},  1'b1, '{ST_DONE,  10'd0, 4'd0}},
      '{'{FN_ENQUEUE, 10'd7,    4'd9},  1'b1, '{ST_DONE,  10'd0, 4'd0}},
      '{'{FN_ENQUEUE, 10'd341,  4'd6},  1'b1, '{ST_DONE,  10'd0, 4'd0}},
      '{'{FN_DEQUEUE, 10'd1023, 4'd15}, 1'b0, '0},
      '{'{FN_DEQUEUE, 10'd0,    4'd0},  1'b0, '0},
      '{'{FN_DEQUEUE, 10'd682,  4'd10}, 1'b0, '0},
      '{'{FN_DEQUEUE, 10'd341,  4'd5},  1'b0, '0},
      '{'{FN_DEQUEUE, 10'd0,    4'd0},  1'b0, '0},
      '{'{FN_DEQUEUE, 10'd1023, 4'd15}, 1'b1, '{ST_EMPTY, 10'd0, 4'd0}},
      '{'{FN_ASSIGN,  10'd0,    4'd15}, 1'b1, '{ST_DONE,  10'd0, 4'd0}},
      '{'{FN_ENQUEUE, 10'd0,    4'd0},  1'b1, '{ST_DONE,  10'd0, 4'd0}},
      '{'{FN_ENQUEUE, 10'd0,    4'd0},  1'b1, '{ST_DONE,  10'd0, 4'd0}},
      '{'{FN_DEQUEUE, 10'd0,    4'd0},  1'b0, '0},
      '{'{FN_DEQUEUE, 10'd0,    4'd0},  1'b0, '0},
      '{'{FN_DEQUEUE, 10'd0,    4'd0},  1'b1, '{ST_EMPTY, 10'd0, 4'd0}}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The block clears its team table first; offer() simply waits on ready.
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    // Mixed traffic with idling on both sides.
    run_segment(SEG_MIXED, 200, 1'b1, 0);

    // The sender holds back until every outstanding result has arrived.
    idle_sender(1);
    wait_drained();

    // Fill the store past its capacity so that enqueues get dropped. At the
    // start the receiver is held off for a long stretch while the sender
    // keeps offering, which backs the block up and stalls its input.
    long_stall_req = 1'b1;
    run_segment(SEG_FILL, 400, 1'b1, 60);

    // Drain the team order down to empty and beyond.
    run_segment(SEG_DRAIN, 380, 1'b1, 0);

    idle_sender(1);
    wait_drained();

    // Tail of the run at full rate with no idling anywhere.
    quiet = 1'b1;
    run_segment(SEG_MIXED, 200, 1'b0, 0);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
